/* src/fr_pkg.sv */
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types and fixed-point constants of the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int IDX_W   = 14;               // Q2.12 refraction index
  localparam int ROOT_W  = 31;               // Q30 cosine and sine, value up to 1.0
  localparam int FRAC_W  = 30;               // Q30 fraction bits
  localparam int ARG_W   = 2 * ROOT_W;       // Q60 square-root argument
  localparam int PROD_W  = IDX_W + ROOT_W;   // index times Q30 value
  localparam int DEN_W   = PROD_W + 1;       // sum of two such products
  localparam int KR_W    = 16;

  localparam logic [IDX_W-1:0]  IDX_ONE = 14'd4096;
  localparam logic [ROOT_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [ARG_W-1:0]  Q60_ONE = 62'h1000_0000_0000_0000;
  localparam logic [KR_W-1:0]   KR_ONE  = 16'h8000;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [IDX_W-1:0]   refr_index;
  } in_t;

  typedef struct packed {
    logic [KR_W-1:0] reflectance;
    logic            total_internal;
  } out_t;

  // Geometry of one item after the dot product stage
  typedef struct packed {
    logic [ROOT_W-1:0] ci;
    logic              leaving;
    logic [IDX_W-1:0]  n;
  } front_t;

endpackage

/* src/fr_isqrt.sv */
// ----------------------------------------------------------------------------
// fr_isqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module fr_isqrt #(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] arg_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int AW = 2 * RW;

  logic          v_q    [RW];
  logic [AW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;
    logic          v_in;
    logic [AW-1:0] rem_in;
    logic [AW-1:0] term;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = arg_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    // (r + 2^k)^2 - r^2
    assign term = (AW'(root_in) << (K + 1)) + (AW'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    // Keep the bit when the remainder covers the trial term
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= term) begin
          rem_q[i]  <= rem_in - term;
          root_q[i] <= root_in | (RW'(1) << K);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

/* src/fr_div.sv */
// ----------------------------------------------------------------------------
// fr_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must lie below the divisor; low bits are shifted in MSB first.
// ----------------------------------------------------------------------------
module fr_div #(
  parameter int DENW = 46,
  parameter int QW   = 30,
  parameter int SW   = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DENW-1:0] rem_i,
  input  logic [QW-1:0]   low_i,
  input  logic [DENW-1:0] den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o,
  output logic [SW-1:0]   side_o
);

  logic            v_q    [QW];
  logic [DENW-1:0] rem_q  [QW];
  logic [DENW-1:0] den_q  [QW];
  logic [QW-1:0]   low_q  [QW];
  logic [QW-1:0]   quo_q  [QW];
  logic [SW-1:0]   side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic            v_in;
    logic [DENW-1:0] rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   low_in;
    logic [QW-1:0]   quo_in;
    logic [SW-1:0]   side_in;
    logic [DENW:0]   trial;
    logic [DENW:0]   diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign low_in  = low_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign low_in  = low_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, low_in[QW-1-i]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    // Subtract when the shifted remainder reaches the divisor
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        quo_q[i]  <= {quo_in[QW-2:0], ge};
        den_q[i]  <= den_in;
        low_q[i]  <= low_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

/* src/fr_dot.sv */
// ----------------------------------------------------------------------------
// fr_dot
// Dot product of direction and normal, side decision and Q30 cosine.
// ----------------------------------------------------------------------------
module fr_dot import fr_pkg::*; #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  in_t    item_i,
  output logic   valid_o,
  output front_t front_o
);

  localparam int FB2 = 2 * VEC_FRAC_BITS;
  localparam int SHR = (FB2 >= FRAC_W) ? FB2 - FRAC_W : 0;
  localparam int SHL = (FB2 <  FRAC_W) ? FRAC_W - FB2 : 0;
  localparam logic [60:0] ONE2 = 61'(1) << FB2;

  logic               v1_q;
  logic signed [31:0] p0_q, p1_q, p2_q;
  logic [IDX_W-1:0]   n1_q;
  logic               v2_q;
  front_t             f2_q;

  logic signed [33:0] sum;
  logic [32:0]        mag;
  logic [60:0]        mag_w;
  logic [60:0]        mag_c;
  logic [60:0]        ci_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Register the three products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= 32'(item_i.dir_x) * 32'(item_i.norm_x);
      p1_q <= 32'(item_i.dir_y) * 32'(item_i.norm_y);
      p2_q <= 32'(item_i.dir_z) * 32'(item_i.norm_z);
      n1_q <= item_i.refr_index;
    end
  end

  // Sum, take the magnitude, clamp to 1.0 and align to Q30
  assign sum   = 34'(p0_q) + 34'(p1_q) + 34'(p2_q);
  assign mag   = sum[33] ? 33'(-sum) : 33'(sum);
  assign mag_w = 61'(mag);
  assign mag_c = (mag_w > ONE2) ? ONE2 : mag_w;
  assign ci_w  = (mag_c >> SHR) << SHL;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f2_q.ci      <= ci_w[ROOT_W-1:0];
      f2_q.leaving <= ~sum[33] && (sum != '0);
      f2_q.n       <= n1_q;
    end
  end

  assign valid_o = v2_q;
  assign front_o = f2_q;

endmodule

/* src/fresnel_reflectance.sv */
// Depth: 130 register stages, counting the one that accepts an item, up to
// the output register that makes its result valid.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output register.
// The depth is set mostly by two 31-stage square roots and two 30-stage dividers.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance of a dielectric surface in fixed point.
// ----------------------------------------------------------------------------
module fresnel_reflectance import fr_pkg::*; #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_item_o
);

  typedef struct packed {
    front_t            f;
    logic              tir;
    logic [FRAC_W-1:0] st_l;
  } st_side_t;

  typedef struct packed {
    front_t f;
    logic   tir;
  } ct_side_t;

  typedef struct packed {
    logic tir;
    logic sat_s;
  } rs_side_t;

  logic adv;
  logic out_valid_q;
  out_t out_item_q;

  // Advance everything unless a result is stuck at the output
  assign adv        = out_ready_i | ~out_valid_q;
  assign in_ready_o = adv;

  // ---- dot product and cosine ----
  logic   v1;
  front_t f1;

  fr_dot #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (v1),
    .front_o (f1)
  );

  // ---- sine of incidence argument ----
  logic             v2_q;
  logic [ARG_W-1:0] arg2_q;
  front_t           f2_q;
  logic [ARG_W-1:0] ci_sq;

  assign ci_sq = {31'b0, f1.ci} * {31'b0, f1.ci};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      arg2_q <= Q60_ONE - ci_sq;
      f2_q   <= f1;
    end
  end

  // ---- sin_i ----
  logic              v3;
  logic [ROOT_W-1:0] si;
  front_t            f3;

  fr_isqrt #(.RW(ROOT_W), .SW($bits(front_t))) u_sqrt_i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .arg_i   (arg2_q),
    .side_i  (f2_q),
    .valid_o (v3),
    .root_o  (si),
    .side_o  (f3)
  );

  // ---- Snell: products and entering check ----
  logic              va_q;
  front_t            fa_q;
  logic [PROD_W-1:0] prod_a_q;
  logic [IDX_W-1:0]  rem0_a_q;
  logic [FRAC_W-1:0] low_a_q;
  logic              tire_a_q;
  logic [IDX_W-1:0]  si_hi;

  assign si_hi = IDX_W'(si >> 18);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q     <= f3;
      prod_a_q <= PROD_W'(si) * PROD_W'(f3.n);
      rem0_a_q <= si_hi;
      low_a_q  <= {si[17:0], 12'b0};
      tire_a_q <= si_hi >= f3.n;
    end
  end

  // Leaving side is a product; entering side goes through the divider
  logic [32:0]      st_l;
  logic             tir_b;
  st_side_t         side_b;
  logic [IDX_W-1:0] rem0_b;

  assign st_l   = prod_a_q[PROD_W-1:12];
  assign tir_b  = fa_q.leaving ? (st_l >= 33'(Q30_ONE)) : tire_a_q;
  assign rem0_b = (fa_q.leaving || tire_a_q) ? '0 : rem0_a_q;
  assign side_b = '{f: fa_q, tir: tir_b, st_l: st_l[FRAC_W-1:0]};

  logic              v4;
  logic [FRAC_W-1:0] q_st;
  st_side_t          side4;

  fr_div #(.DENW(IDX_W), .QW(FRAC_W), .SW($bits(st_side_t))) u_div_st (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (va_q),
    .rem_i   (rem0_b),
    .low_i   (low_a_q),
    .den_i   (fa_q.n),
    .side_i  (side_b),
    .valid_o (v4),
    .quo_o   (q_st),
    .side_o  (side4)
  );

  // ---- cosine of transmission argument ----
  logic              vc_q;
  logic [ARG_W-1:0]  argc_q;
  ct_side_t          sidec_q;
  logic [FRAC_W-1:0] st;
  logic [ARG_W-1:0]  st_sq;

  always_comb begin
    if (side4.tir) begin
      st = '0;
    end else if (side4.f.leaving) begin
      st = side4.st_l;
    end else begin
      st = q_st;
    end
  end

  assign st_sq = {32'b0, st} * {32'b0, st};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      argc_q      <= Q60_ONE - st_sq;
      sidec_q.f   <= side4.f;
      sidec_q.tir <= side4.tir;
    end
  end

  logic              v5;
  logic [ROOT_W-1:0] ct;
  ct_side_t          side5;

  fr_isqrt #(.RW(ROOT_W), .SW($bits(ct_side_t))) u_sqrt_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vc_q),
    .arg_i   (argc_q),
    .side_i  (sidec_q),
    .valid_o (v5),
    .root_o  (ct),
    .side_o  (side5)
  );

  // ---- ratio operands ----
  logic              vr_q;
  logic              tirr_q;
  logic [PROD_W-1:0] xs_q, ys_q, xp_q, yp_q;
  logic [IDX_W-1:0]  eti, ett;

  assign eti = side5.f.leaving ? side5.f.n : IDX_ONE;
  assign ett = side5.f.leaving ? IDX_ONE : side5.f.n;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xs_q   <= PROD_W'(ett) * PROD_W'(side5.f.ci);
      ys_q   <= PROD_W'(eti) * PROD_W'(ct);
      xp_q   <= PROD_W'(eti) * PROD_W'(side5.f.ci);
      yp_q   <= PROD_W'(ett) * PROD_W'(ct);
      tirr_q <= side5.tir;
    end
  end

  // Difference over sum; a ratio of one or more saturates
  logic [DEN_W-1:0] den_s, num_s, den_p, num_p;
  logic             sat_s, sat_p;
  rs_side_t         side_s;

  assign den_s  = DEN_W'(xs_q) + DEN_W'(ys_q);
  assign num_s  = (xs_q > ys_q) ? DEN_W'(xs_q - ys_q) : DEN_W'(ys_q - xs_q);
  assign den_p  = DEN_W'(xp_q) + DEN_W'(yp_q);
  assign num_p  = (xp_q > yp_q) ? DEN_W'(xp_q - yp_q) : DEN_W'(yp_q - xp_q);
  assign sat_s  = (den_s == '0) || (num_s >= den_s);
  assign sat_p  = (den_p == '0) || (num_p >= den_p);
  assign side_s = '{tir: tirr_q, sat_s: sat_s};

  logic              v6;
  logic [FRAC_W-1:0] q_s, q_p;
  rs_side_t          side6;
  logic              sat_p6;

  fr_div #(.DENW(DEN_W), .QW(FRAC_W), .SW($bits(rs_side_t))) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vr_q),
    .rem_i   (sat_s ? '0 : num_s),
    .low_i   ('0),
    .den_i   (den_s),
    .side_i  (side_s),
    .valid_o (v6),
    .quo_o   (q_s),
    .side_o  (side6)
  );

  fr_div #(.DENW(DEN_W), .QW(FRAC_W), .SW(1)) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vr_q),
    .rem_i   (sat_p ? '0 : num_p),
    .low_i   ('0),
    .den_i   (den_p),
    .side_i  (sat_p),
    .valid_o (),
    .quo_o   (q_p),
    .side_o  (sat_p6)
  );

  // ---- squared ratios ----
  logic              vq_q;
  logic              tirq_q;
  logic [ROOT_W-1:0] rs_q, rp_q;
  logic [ROOT_W-1:0] qs, qp;
  logic [ARG_W-1:0]  qs_sq, qp_sq;

  assign qs    = side6.sat_s ? Q30_ONE : ROOT_W'(q_s);
  assign qp    = sat_p6 ? Q30_ONE : ROOT_W'(q_p);
  assign qs_sq = {31'b0, qs} * {31'b0, qs};
  assign qp_sq = {31'b0, qp} * {31'b0, qp};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q   <= qs_sq[FRAC_W+ROOT_W-1:FRAC_W];
      rp_q   <= qp_sq[FRAC_W+ROOT_W-1:FRAC_W];
      tirq_q <= side6.tir;
    end
  end

  // ---- mean and saturation into the output register ----
  logic [31:0] kr_sum;
  logic [15:0] kr;

  assign kr_sum = 32'(rs_q) + 32'(rp_q);
  assign kr     = (kr_sum[31:16] > 16'(KR_ONE)) ? KR_ONE : kr_sum[31:16];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.reflectance    <= tirq_q ? KR_ONE : kr;
      out_item_q.total_internal <= tirq_q;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      va_q        <= 1'b0;
      vc_q        <= 1'b0;
      vr_q        <= 1'b0;
      vq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v2_q        <= v1;
      va_q        <= v3;
      vc_q        <= v4;
      vr_q        <= v5;
      vq_q        <= v6;
      out_valid_q <= vq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* src/fr_checker.sv */
// ----------------------------------------------------------------------------
// fr_checker
// Port-level checks of the Fresnel reflectance block, bound to the top level.
// ----------------------------------------------------------------------------
module fr_checker import fr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_item_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_item_o
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // Total internal reflection always reports full reflectance
  a_tir_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.total_internal |-> out_item_o.reflectance == KR_ONE)
    else $error("total internal reflection without full reflectance");

  // Reflectance never exceeds 1.0
  a_kr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.reflectance <= KR_ONE)
    else $error("reflectance above one");

  // A blocked output stalls the input side
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline stalled");

  // No valid result right after reset has been sampled asserted
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind fresnel_reflectance fr_checker u_fr_checker (.*);
